// File: rtl/rvx_pkg.sv
// ---------------------------------------------------------------------------
// rvx_pkg
// shared types and codes for the execute unit
// ---------------------------------------------------------------------------
package rvx_pkg;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_SUB   = 6'd1;
    localparam logic [5:0] OP_XOR   = 6'd2;
    localparam logic [5:0] OP_OR    = 6'd3;
    localparam logic [5:0] OP_AND   = 6'd4;
    localparam logic [5:0] OP_SLL   = 6'd5;
    localparam logic [5:0] OP_SRL   = 6'd6;
    localparam logic [5:0] OP_MUL   = 6'd7;
    localparam logic [5:0] OP_DIV   = 6'd8;
    localparam logic [5:0] OP_REM   = 6'd9;
    localparam logic [5:0] OP_ADDI  = 6'd10;
    localparam logic [5:0] OP_XORI  = 6'd11;
    localparam logic [5:0] OP_ORI   = 6'd12;
    localparam logic [5:0] OP_ANDI  = 6'd13;
    localparam logic [5:0] OP_SLLI  = 6'd14;
    localparam logic [5:0] OP_SRLI  = 6'd15;
    localparam logic [5:0] OP_LB    = 6'd16;
    localparam logic [5:0] OP_LH    = 6'd17;
    localparam logic [5:0] OP_LW    = 6'd18;
    localparam logic [5:0] OP_SB    = 6'd19;
    localparam logic [5:0] OP_SH    = 6'd20;
    localparam logic [5:0] OP_SW    = 6'd21;
    localparam logic [5:0] OP_BEQ   = 6'd22;
    localparam logic [5:0] OP_BNE   = 6'd23;
    localparam logic [5:0] OP_BLT   = 6'd24;
    localparam logic [5:0] OP_BGE   = 6'd25;
    localparam logic [5:0] OP_BGT   = 6'd26;
    localparam logic [5:0] OP_BLE   = 6'd27;
    localparam logic [5:0] OP_LI    = 6'd28;
    localparam logic [5:0] OP_MV    = 6'd29;
    localparam logic [5:0] OP_CALL  = 6'd30;
    localparam logic [5:0] OP_J     = 6'd31;
    localparam logic [5:0] OP_ECALL = 6'd32;
    localparam logic [5:0] OP_RET   = 6'd33;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_PINT = 3'd1;
    localparam logic [2:0] EV_PCHR = 3'd2;
    localparam logic [2:0] EV_EXIT = 3'd3;
    localparam logic [2:0] EV_ERR  = 3'd4;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_WRZERO = 3'd1;
    localparam logic [2:0] ERR_DIV0   = 3'd2;
    localparam logic [2:0] ERR_RET    = 3'd3;
    localparam logic [2:0] ERR_ECALL  = 3'd4;
    localparam logic [2:0] ERR_ADDR   = 3'd5;

    localparam logic [31:0] SVC_PINT = 32'd1;
    localparam logic [31:0] SVC_EXIT = 32'd10;
    localparam logic [31:0] SVC_PCHR = 32'd11;

    localparam logic [4:0] REG_RA = 5'd1;
    localparam logic [4:0] REG_SP = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;

    localparam logic [1:0] PADDR_PLEN = 2'd0;

    // one queued instruction as the front end classified it
    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  dest_reg;
        logic [4:0]  src_a;
        logic [4:0]  src_b;
        logic [31:0] immediate;
        logic [15:0] target;
        logic        is_div;   // div or rem, goes to the divider
        logic        is_mem;   // load or store
        logic        is_load;
        logic [2:0]  size;     // bytes moved by a memory op
    } rvx_instr_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [2:0]  event_res;
        logic [31:0] value;
        logic [2:0]  error_kind;
    } rvx_result_t;

endpackage

// File: rtl/rvx_front.sv
// ---------------------------------------------------------------------------
// rvx_front
// accepts requests, classifies them and holds them in a two-entry queue
// ---------------------------------------------------------------------------
module rvx_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [5:0]          op,
    input  logic [4:0]          dest_reg,
    input  logic [4:0]          src_a,
    input  logic [4:0]          src_b,
    input  logic signed [31:0]  immediate,
    input  logic [15:0]         target,
    output logic                q_valid,
    output rvx_pkg::rvx_instr_t q_data,
    input  logic                q_pop
);

    rvx_pkg::rvx_instr_t ent_reg [2];
    logic                rd_ptr_reg, rd_ptr_next;
    logic                wr_ptr_reg, wr_ptr_next;
    logic [1:0]          cnt_reg, cnt_next;
    rvx_pkg::rvx_instr_t cls;
    logic                push;
    logic                pop;

    always_comb
    begin
        cls.op        = op;
        cls.dest_reg  = dest_reg;
        cls.src_a     = src_a;
        cls.src_b     = src_b;
        cls.immediate = immediate;
        cls.target    = target;
        cls.is_div    = (op == rvx_pkg::OP_DIV) || (op == rvx_pkg::OP_REM);
        cls.is_mem    = (op >= rvx_pkg::OP_LB) && (op <= rvx_pkg::OP_SW);
        cls.is_load   = (op >= rvx_pkg::OP_LB) && (op <= rvx_pkg::OP_LW);
        if (op == rvx_pkg::OP_LB || op == rvx_pkg::OP_SB)
            cls.size = 3'd1;
        else if (op == rvx_pkg::OP_LH || op == rvx_pkg::OP_SH)
            cls.size = 3'd2;
        else
            cls.size = 3'd4;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= cls;
    end

endmodule

// File: rtl/rvx_div.sv
// ---------------------------------------------------------------------------
// rvx_div
// signed radix-2 divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rvx_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[30:0], q_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend[31] ? (32'd0 - dividend) : dividend;
            d_next    = divisor[31] ? (32'd0 - divisor) : divisor;
            r_next    = 32'd0;
            qneg_next = dividend[31] ^ divisor[31];
            rneg_next = dividend[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32] || r_reg[31])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (32'd0 - q_reg) : q_reg;
    assign remainder = rneg_reg ? (32'd0 - r_reg) : r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

endmodule

// File: rtl/rvx_back.sv
// ---------------------------------------------------------------------------
// rvx_back
// executes queued instructions: register file, stack memory, divider
// ---------------------------------------------------------------------------
module rvx_back #(
    parameter int STACK_BYTES = 262144
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rvx_pkg::rvx_instr_t  q_data,
    output logic                 q_pop,
    input  logic [15:0]          program_length,
    output logic                 res_valid,
    output rvx_pkg::rvx_result_t res_data,
    input  logic                 res_stall
);

    localparam int AW = $clog2(STACK_BYTES);

    typedef enum logic [5:0] {
        ST_READ  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_MEM   = 6'b001000,
        ST_LOAD  = 6'b010000,
        ST_WRITE = 6'b100000
    } st_t;

    st_t                  st_reg, st_next;
    logic [31:0]          regs_reg [32];
    logic [31:0]          a_reg, b_reg, sp_reg, ra_reg, a0_reg, a1_reg;
    logic [15:0]          pc_reg, pc_next;
    logic                 halted_reg, halted_next;
    rvx_pkg::rvx_result_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 wr_en;
    logic [4:0]           wr_idx;
    logic [31:0]          wr_val;
    logic [31:0]          wr_val_reg, wr_val_next;
    logic                 wr_pend_next;
    logic [31:0]          addr_reg, addr_next;
    logic [1:0]           bidx_reg, bidx_next;
    logic [31:0]          ld_reg, ld_next;
    logic [7:0]           mem [STACK_BYTES];
    logic [7:0]           mem_q_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [7:0]           mem_wd;
    logic                 div_start, div_done;
    logic [31:0]          div_q, div_r;
    logic [31:0]          alu;
    logic [31:0]          y;
    logic [15:0]          pc_inc;
    logic                 take;
    logic [32:0]          end_addr;
    logic [31:0]          ld_ext;
    logic [2:0]           ev;
    logic [2:0]           err;
    logic [31:0]          val;
    logic [15:0]          nxt;
    logic                 out_free;

    rvx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;
    assign out_free  = !out_valid_reg || !res_stall;
    assign pc_inc    = pc_reg + 16'd1;
    assign y         = (q_data.op >= rvx_pkg::OP_ADDI) ? q_data.immediate : b_reg;
    assign end_addr  = {1'b0, addr_reg} + {30'd0, q_data.size};

    always_comb
    begin
        case (q_data.op)
            rvx_pkg::OP_ADD, rvx_pkg::OP_ADDI: alu = a_reg + y;
            rvx_pkg::OP_SUB:                   alu = a_reg - y;
            rvx_pkg::OP_XOR, rvx_pkg::OP_XORI: alu = a_reg ^ y;
            rvx_pkg::OP_OR,  rvx_pkg::OP_ORI:  alu = a_reg | y;
            rvx_pkg::OP_AND, rvx_pkg::OP_ANDI: alu = a_reg & y;
            rvx_pkg::OP_SLL, rvx_pkg::OP_SLLI: alu = a_reg << y[4:0];
            rvx_pkg::OP_SRL, rvx_pkg::OP_SRLI: alu = a_reg >> y[4:0];
            rvx_pkg::OP_MUL:                   alu = a_reg * y;
            rvx_pkg::OP_LI:                    alu = q_data.immediate;
            default:                           alu = a_reg;
        endcase
        case (q_data.op)
            rvx_pkg::OP_BEQ: take = (a_reg == b_reg);
            rvx_pkg::OP_BNE: take = (a_reg != b_reg);
            rvx_pkg::OP_BLT: take = ($signed(a_reg) < $signed(b_reg));
            rvx_pkg::OP_BGE: take = ($signed(a_reg) >= $signed(b_reg));
            rvx_pkg::OP_BGT: take = ($signed(a_reg) > $signed(b_reg));
            rvx_pkg::OP_BLE: take = ($signed(a_reg) <= $signed(b_reg));
            default:         take = 1'b0;
        endcase
        case (q_data.size)
            3'd1:    ld_ext = {{24{ld_reg[7]}}, ld_reg[7:0]};
            3'd2:    ld_ext = {{16{ld_reg[15]}}, ld_reg[15:0]};
            default: ld_ext = ld_reg;
        endcase
    end

    always_comb
    begin
        st_next        = st_reg;
        pc_next        = pc_reg;
        halted_next    = halted_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && res_stall;
        wr_en          = 1'b0;
        wr_idx         = q_data.dest_reg;
        wr_val         = alu;
        wr_val_next    = wr_val_reg;
        wr_pend_next   = 1'b0;
        addr_next      = addr_reg;
        bidx_next      = bidx_reg;
        ld_next        = ld_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_reg[AW-1:0] + AW'(bidx_reg);
        mem_wd         = b_reg[8*bidx_reg +: 8];
        div_start      = 1'b0;
        q_pop          = 1'b0;
        ev             = rvx_pkg::EV_NONE;
        err            = rvx_pkg::ERR_NONE;
        val            = 32'd0;
        nxt            = pc_inc;
        case (st_reg)
            ST_READ:
            begin
                if (q_valid)
                    st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (halted_reg)
                begin
                    nxt = pc_reg;
                    if (out_free)
                        wr_pend_next = 1'b1;
                end
                else if (q_data.is_div)
                begin
                    if (b_reg == 32'd0)
                    begin
                        ev  = rvx_pkg::EV_ERR;
                        err = rvx_pkg::ERR_DIV0;
                        if (out_free)
                            wr_pend_next = 1'b1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        st_next   = ST_DIV;
                    end
                end
                else if (q_data.is_mem)
                begin
                    if (q_data.is_load && (q_data.dest_reg == 5'd0 ||
                        q_data.dest_reg == rvx_pkg::REG_SP))
                    begin
                        ev  = rvx_pkg::EV_ERR;
                        err = rvx_pkg::ERR_WRZERO;
                        if (out_free)
                            wr_pend_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = sp_reg + q_data.immediate;
                        bidx_next = 2'd0;
                        ld_next   = 32'd0;
                        st_next   = ST_MEM;
                    end
                end
                else
                begin
                    case (q_data.op)
                        rvx_pkg::OP_LI:
                        begin
                            if (q_data.dest_reg == 5'd0 || q_data.dest_reg == rvx_pkg::REG_SP)
                            begin
                                ev  = rvx_pkg::EV_ERR;
                                err = rvx_pkg::ERR_WRZERO;
                            end
                            else
                                wr_en = 1'b1;
                        end
                        rvx_pkg::OP_CALL:
                        begin
                            wr_en  = 1'b1;
                            wr_idx = rvx_pkg::REG_RA;
                            wr_val = {15'd0, {1'b0, pc_reg} + 17'd1};
                            nxt    = q_data.target;
                        end
                        rvx_pkg::OP_J: nxt = q_data.target;
                        rvx_pkg::OP_ECALL:
                        begin
                            if (a0_reg == rvx_pkg::SVC_PINT)
                            begin
                                ev  = rvx_pkg::EV_PINT;
                                val = a1_reg;
                            end
                            else if (a0_reg == rvx_pkg::SVC_PCHR)
                            begin
                                ev  = rvx_pkg::EV_PCHR;
                                val = {24'd0, a1_reg[7:0]};
                            end
                            else if (a0_reg == rvx_pkg::SVC_EXIT)
                            begin
                                ev  = rvx_pkg::EV_EXIT;
                                val = a1_reg;
                            end
                            else
                            begin
                                ev  = rvx_pkg::EV_ERR;
                                err = rvx_pkg::ERR_ECALL;
                            end
                        end
                        rvx_pkg::OP_RET:
                        begin
                            if (ra_reg >= {16'd0, program_length})
                            begin
                                ev  = rvx_pkg::EV_ERR;
                                err = rvx_pkg::ERR_RET;
                            end
                            else
                                nxt = ra_reg[15:0];
                        end
                        default:
                        begin
                            if (q_data.op <= rvx_pkg::OP_SRLI || q_data.op == rvx_pkg::OP_MV)
                                wr_en = 1'b1;
                            else if (take)
                                nxt = q_data.target;
                        end
                    endcase
                    if (!out_free)
                        wr_en = 1'b0;
                    else
                        wr_pend_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr_val_next = (q_data.op == rvx_pkg::OP_DIV) ? div_q : div_r;
                    st_next     = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    wr_en        = 1'b1;
                    wr_val       = wr_val_reg;
                    wr_pend_next = 1'b1;
                end
            end
            ST_MEM:
            begin
                if (end_addr > 33'(STACK_BYTES))
                begin
                    ev  = rvx_pkg::EV_ERR;
                    err = rvx_pkg::ERR_ADDR;
                    if (out_free)
                        wr_pend_next = 1'b1;
                end
                else if (!q_data.is_load)
                begin
                    mem_we    = 1'b1;
                    bidx_next = bidx_reg + 2'd1;
                    if ({1'b0, bidx_reg} + 3'd1 == q_data.size)
                    begin
                        bidx_next = bidx_reg;
                        mem_we    = out_free;
                        if (out_free)
                            wr_pend_next = 1'b1;
                    end
                end
                else
                    st_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // read data of the current byte address, registered during ST_MEM, is in mem_q_reg
                ld_next = ld_reg | ({24'd0, mem_q_reg} << (8 * bidx_reg));
                if ({1'b0, bidx_reg} + 3'd1 == q_data.size)
                begin
                    wr_val_next = ld_next;
                    st_next     = ST_WRITE;
                end
                else
                begin
                    bidx_next = bidx_reg + 2'd1;
                    st_next   = ST_MEM;
                end
            end
            default: st_next = ST_READ;
        endcase

        if (q_data.is_load && st_reg == ST_WRITE)
            wr_val = {ld_ext[31:0]};
        if (wr_pend_next)
        begin
            // retire the instruction: publish the result, update pc and pop the queue
            if (!halted_reg && (ev == rvx_pkg::EV_EXIT || ev == rvx_pkg::EV_ERR))
            begin
                halted_next = 1'b1;
                nxt         = pc_reg;
            end
            pc_next             = nxt;
            out_next.next_pc    = nxt;
            out_next.event_res  = ev;
            out_next.value      = val;
            out_next.error_kind = err;
            out_valid_next      = 1'b1;
            q_pop               = 1'b1;
            st_next             = ST_READ;
        end
    end

    // the byte read for a load is registered into mem_q_reg during its ST_MEM visit, one visit per byte
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        mem_q_reg <= mem[mem_addr];
        a_reg  <= regs_reg[q_data.src_a];
        b_reg  <= regs_reg[q_data.src_b];
        sp_reg <= regs_reg[rvx_pkg::REG_SP];
        ra_reg <= regs_reg[rvx_pkg::REG_RA];
        a0_reg <= regs_reg[rvx_pkg::REG_A0];
        a1_reg <= regs_reg[rvx_pkg::REG_A1];
        wr_val_reg <= wr_val_next;
        addr_reg   <= addr_next;
        bidx_reg   <= bidx_next;
        ld_reg     <= ld_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_READ;
            pc_reg        <= 16'd0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 32; i++)
                regs_reg[i] <= (5'(i) == rvx_pkg::REG_SP) ? 32'(STACK_BYTES) : 32'd0;
        end
        else
        begin
            st_reg        <= st_next;
            pc_reg        <= pc_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (wr_en && wr_idx != 5'd0)
                regs_reg[wr_idx] <= wr_val;
        end
    end

endmodule

// File: rtl/rv32im_subset_execute_unit.sv
// ---------------------------------------------------------------------------
// rv32im_subset_execute_unit
// executes decoded instructions of a small rv32im-style subset
// ---------------------------------------------------------------------------
// channel   direction  handshake             payload
// request   in         in_valid / in_stall   op dest_reg src_a src_b immediate target
// result    out        out_valid / out_stall next_pc event_res value error_kind
// config    in         apb write/read        program_length at address 0
//
// simple ops pass through register read, then execute/retire
// loads visit ST_MEM then ST_LOAD per byte; stores write a byte per ST_MEM visit
// div and rem wait in ST_DIV for the one-bit-per-cycle divider
// a two-entry queue lets requests arrive while the back end works
// reset clears registers (sp = STACK_BYTES), pc, halt flag and queue
// stack memory is not cleared; it holds garbage until stored
// ---------------------------------------------------------------------------
module rv32im_subset_execute_unit #(
    parameter int STACK_BYTES = 262144
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [5:0]         op,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_a,
    input  logic [4:0]         src_b,
    input  logic signed [31:0] immediate,
    input  logic [15:0]        target,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        next_pc,
    output logic [2:0]         event_res,
    output logic signed [31:0] value,
    output logic [2:0]         error_kind,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic                 q_valid;
    rvx_pkg::rvx_instr_t  q_data;
    logic                 q_pop;
    rvx_pkg::rvx_result_t res;
    logic [15:0]          plen_reg;

    // program_length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plen_reg <= 16'hFFFF;
        else if (psel && penable && pwrite && paddr == rvx_pkg::PADDR_PLEN)
            plen_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == rvx_pkg::PADDR_PLEN) ? {16'd0, plen_reg} : 32'd0;

    rvx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .dest_reg  (dest_reg),
        .src_a     (src_a),
        .src_b     (src_b),
        .immediate (immediate),
        .target    (target),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    rvx_back #(
        .STACK_BYTES (STACK_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .program_length (plen_reg),
        .res_valid      (out_valid),
        .res_data       (res),
        .res_stall      (out_stall)
    );

    assign next_pc    = res.next_pc;
    assign event_res  = res.event_res;
    assign value      = res.value;
    assign error_kind = res.error_kind;

endmodule

// File: dv/rv32im_subset_execute_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rv32im_subset_execute_unit_test
// self-checking bench for the rv32im subset execute unit: a directed
// instruction list, then legal random programs driven through the request
// channel with random idling on both sides, checked against a behavioral
// model of the register file, stack memory and pc
// ---------------------------------------------------------------------------
module rv32im_subset_execute_unit_test;

    localparam int          STACK      = 262144;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          PHASE_REQS = 380;

    // one decoded instruction as it crosses the request channel
    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        logic [15:0] tgt;
    } instr_t;

    // directed row: instruction plus an optional hand-written result
    typedef struct {
        instr_t               ins;
        bit                   typed;
        rvx_pkg::rvx_result_t want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [5:0]         op;
    logic [4:0]         dest_reg;
    logic [4:0]         src_a;
    logic [4:0]         src_b;
    logic signed [31:0] immediate;
    logic [15:0]        target;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        next_pc;
    logic [2:0]         event_res;
    logic signed [31:0] value;
    logic [2:0]         error_kind;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    rv32im_subset_execute_unit #(.STACK_BYTES(STACK)) DUT (.*);

    // model state of the core
    logic [31:0] gpr [32];
    logic [7:0]  stack_mem [int unsigned];
    logic [15:0] model_pc;
    logic        model_halted;
    logic [15:0] model_plen;

    rvx_pkg::rvx_result_t pending_results[$];
    int                   fail_count;
    int                   idle_cycles;
    int                   send_gap_max;
    int                   recv_stall_max;
    bit                   hold_request;
    plan_row_t            plan[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic instr_t mk(logic [5:0] o, logic [4:0] d, logic [4:0] a,
                                  logic [4:0] b, logic [31:0] i, logic [15:0] t);
        instr_t r;
        r.op = o; r.rd = d; r.ra = a; r.rb = b; r.imm = i; r.tgt = t;
        return r;
    endfunction

    // appends one directed row to the plan
    function automatic void add_row(plan_row_t row);
        plan.insert(plan.size(), row);
    endfunction

    // executes one instruction on the model state and returns its result
    task automatic execute_instr(input instr_t it, output rvx_pkg::rvx_result_t r);
        logic [31:0] a, b, res, addr, val;
        logic [15:0] nxt;
        logic [2:0]  ev, ek;
        logic [63:0] lim;
        logic        do_wr, take;
        int          sz;
        a = gpr[it.ra];
        b = gpr[it.rb];
        nxt = model_pc + 16'd1;
        ev = rvx_pkg::EV_NONE; ek = rvx_pkg::ERR_NONE;
        val = '0; res = '0; do_wr = 1'b0; take = 1'b0;
        if (model_halted)
        begin
            r = '{model_pc, rvx_pkg::EV_NONE, 32'd0, rvx_pkg::ERR_NONE};
            return;
        end
        case (it.op)
            rvx_pkg::OP_ADD:  begin res = a + b; do_wr = 1'b1; end
            rvx_pkg::OP_SUB:  begin res = a - b; do_wr = 1'b1; end
            rvx_pkg::OP_XOR:  begin res = a ^ b; do_wr = 1'b1; end
            rvx_pkg::OP_OR:   begin res = a | b; do_wr = 1'b1; end
            rvx_pkg::OP_AND:  begin res = a & b; do_wr = 1'b1; end
            rvx_pkg::OP_SLL:  begin res = a << b[4:0]; do_wr = 1'b1; end
            rvx_pkg::OP_SRL:  begin res = a >> b[4:0]; do_wr = 1'b1; end
            rvx_pkg::OP_MUL:  begin res = a * b; do_wr = 1'b1; end
            rvx_pkg::OP_ADDI: begin res = a + it.imm; do_wr = 1'b1; end
            rvx_pkg::OP_XORI: begin res = a ^ it.imm; do_wr = 1'b1; end
            rvx_pkg::OP_ORI:  begin res = a | it.imm; do_wr = 1'b1; end
            rvx_pkg::OP_ANDI: begin res = a & it.imm; do_wr = 1'b1; end
            rvx_pkg::OP_SLLI: begin res = a << it.imm[4:0]; do_wr = 1'b1; end
            rvx_pkg::OP_SRLI: begin res = a >> it.imm[4:0]; do_wr = 1'b1; end
            rvx_pkg::OP_DIV, rvx_pkg::OP_REM:
            begin
                if (b == 32'd0)
                begin
                    ev = rvx_pkg::EV_ERR; ek = rvx_pkg::ERR_DIV0;
                end
                else
                begin
                    do_wr = 1'b1;
                    // riscv overflow rule for the one quotient that does not fit
                    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                        res = (it.op == rvx_pkg::OP_DIV) ? a : 32'd0;
                    else if (it.op == rvx_pkg::OP_DIV)
                        res = $signed(a) / $signed(b);
                    else
                        res = $signed(a) % $signed(b);
                end
            end
            rvx_pkg::OP_LB, rvx_pkg::OP_LH, rvx_pkg::OP_LW,
            rvx_pkg::OP_SB, rvx_pkg::OP_SH, rvx_pkg::OP_SW:
            begin
                sz = (it.op == rvx_pkg::OP_LB || it.op == rvx_pkg::OP_SB) ? 1 :
                     (it.op == rvx_pkg::OP_LH || it.op == rvx_pkg::OP_SH) ? 2 : 4;
                addr = gpr[rvx_pkg::REG_SP] + it.imm;
                lim = {32'd0, addr} + 64'(sz);
                if (it.op <= rvx_pkg::OP_LW && (it.rd == 5'd0 || it.rd == rvx_pkg::REG_SP))
                begin
                    ev = rvx_pkg::EV_ERR; ek = rvx_pkg::ERR_WRZERO;
                end
                else if (lim > 64'(STACK))
                begin
                    ev = rvx_pkg::EV_ERR; ek = rvx_pkg::ERR_ADDR;
                end
                else if (it.op <= rvx_pkg::OP_LW)
                begin
                    for (int i = 0; i < sz; i++)
                        res[8*i +: 8] = stack_mem[addr + i];
                    if (sz == 1) res[31:8] = {24{res[7]}};
                    if (sz == 2) res[31:16] = {16{res[15]}};
                    do_wr = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < sz; i++)
                        stack_mem[addr + i] = b[8*i +: 8];
                end
            end
            rvx_pkg::OP_BEQ, rvx_pkg::OP_BNE, rvx_pkg::OP_BLT,
            rvx_pkg::OP_BGE, rvx_pkg::OP_BGT, rvx_pkg::OP_BLE:
            begin
                case (it.op)
                    rvx_pkg::OP_BEQ: take = (a == b);
                    rvx_pkg::OP_BNE: take = (a != b);
                    rvx_pkg::OP_BLT: take = ($signed(a) < $signed(b));
                    rvx_pkg::OP_BGE: take = ($signed(a) >= $signed(b));
                    rvx_pkg::OP_BGT: take = ($signed(a) > $signed(b));
                    default:         take = ($signed(a) <= $signed(b));
                endcase
                if (take) nxt = it.tgt;
            end
            rvx_pkg::OP_LI:
            begin
                if (it.rd == 5'd0 || it.rd == rvx_pkg::REG_SP)
                begin
                    ev = rvx_pkg::EV_ERR; ek = rvx_pkg::ERR_WRZERO;
                end
                else
                begin
                    res = it.imm; do_wr = 1'b1;
                end
            end
            rvx_pkg::OP_MV:   begin res = a; do_wr = 1'b1; end
            rvx_pkg::OP_CALL:
            begin
                // return address does not wrap, 65536 is possible
                gpr[rvx_pkg::REG_RA] = {16'd0, model_pc} + 32'd1;
                nxt = it.tgt;
            end
            rvx_pkg::OP_J:    nxt = it.tgt;
            rvx_pkg::OP_ECALL:
            begin
                if (gpr[rvx_pkg::REG_A0] == rvx_pkg::SVC_PINT)
                begin
                    ev = rvx_pkg::EV_PINT; val = gpr[rvx_pkg::REG_A1];
                end
                else if (gpr[rvx_pkg::REG_A0] == rvx_pkg::SVC_PCHR)
                begin
                    ev = rvx_pkg::EV_PCHR; val = {24'd0, gpr[rvx_pkg::REG_A1][7:0]};
                end
                else if (gpr[rvx_pkg::REG_A0] == rvx_pkg::SVC_EXIT)
                begin
                    ev = rvx_pkg::EV_EXIT; val = gpr[rvx_pkg::REG_A1];
                end
                else
                begin
                    ev = rvx_pkg::EV_ERR; ek = rvx_pkg::ERR_ECALL;
                end
            end
            rvx_pkg::OP_RET:
            begin
                if (gpr[rvx_pkg::REG_RA] >= {16'd0, model_plen})
                begin
                    ev = rvx_pkg::EV_ERR; ek = rvx_pkg::ERR_RET;
                end
                else
                    nxt = gpr[rvx_pkg::REG_RA][15:0];
            end
            default: ;  // unused opcodes fall through to pc + 1
        endcase
        if (do_wr && ev == rvx_pkg::EV_NONE && it.rd != 5'd0)
            gpr[it.rd] = res;
        if (ev == rvx_pkg::EV_EXIT || ev == rvx_pkg::EV_ERR)
        begin
            model_halted = 1'b1;
            nxt = model_pc;
        end
        model_pc = nxt;
        r = '{nxt, ev, val, ek};
    endtask

    function automatic int unsigned pick_addr(int sz);
        if ($urandom_range(0, 1))
            return $urandom_range(0, 64 - sz);
        return STACK - 64 + $urandom_range(0, 64 - sz);
    endfunction

    // builds a legal random instruction from the current model state;
    // anything that would halt the core is steered into a harmless form
    function automatic instr_t next_instr();
        instr_t      it;
        int          sel, sz;
        int unsigned addr;
        bit          ok;
        it = mk($urandom_range(0, 33), $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom, $urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 6)
            it.op = $urandom_range(34, 63);
        else if (sel < 30)
            it.op = $urandom_range(rvx_pkg::OP_ADD, rvx_pkg::OP_SRLI);
        else if (sel < 55)
        begin
            it.op = $urandom_range(rvx_pkg::OP_LB, rvx_pkg::OP_SW);
            sz = (it.op == rvx_pkg::OP_LB || it.op == rvx_pkg::OP_SB) ? 1 :
                 (it.op == rvx_pkg::OP_LH || it.op == rvx_pkg::OP_SH) ? 2 : 4;
            addr = pick_addr(sz);
            if (it.op <= rvx_pkg::OP_LW)
            begin
                ok = 1'b1;
                for (int i = 0; i < sz; i++)
                    if (!stack_mem.exists(addr + i)) ok = 1'b0;
                if (!ok)
                    it.op = it.op + 6'd3;  // nothing stored there yet, store instead
                else if (it.rd == 5'd0 || it.rd == rvx_pkg::REG_SP)
                    it.rd = $urandom_range(3, 31);
            end
            it.imm = addr - gpr[rvx_pkg::REG_SP];
        end
        else if (sel < 68)
            it.op = $urandom_range(rvx_pkg::OP_BEQ, rvx_pkg::OP_BLE);
        else if (sel < 80)
        begin
            it.op = rvx_pkg::OP_LI;
            if ($urandom_range(0, 3) == 0) it.rd = rvx_pkg::REG_A1;
        end
        else if (sel < 90)
        begin
            // print sequence: set the service number, then ecall
            if (gpr[rvx_pkg::REG_A0] == rvx_pkg::SVC_PINT ||
                gpr[rvx_pkg::REG_A0] == rvx_pkg::SVC_PCHR)
                it.op = rvx_pkg::OP_ECALL;
            else
            begin
                it.op = rvx_pkg::OP_LI; it.rd = rvx_pkg::REG_A0;
                it.imm = $urandom_range(0, 1) ? rvx_pkg::SVC_PINT : rvx_pkg::SVC_PCHR;
            end
        end
        else
            it.op = $urandom_range(rvx_pkg::OP_MV, rvx_pkg::OP_RET);
        if (it.op == rvx_pkg::OP_LI && (it.rd == 5'd0 || it.rd == rvx_pkg::REG_SP))
            it.rd = $urandom_range(3, 31);
        if ((it.op == rvx_pkg::OP_DIV || it.op == rvx_pkg::OP_REM) && gpr[it.rb] == 32'd0)
            it.op = rvx_pkg::OP_ADD;
        if (it.op == rvx_pkg::OP_ECALL && gpr[rvx_pkg::REG_A0] != rvx_pkg::SVC_PINT &&
            gpr[rvx_pkg::REG_A0] != rvx_pkg::SVC_PCHR)
            it.op = rvx_pkg::OP_J;
        if (it.op == rvx_pkg::OP_RET && gpr[rvx_pkg::REG_RA] >= {16'd0, model_plen})
        begin
            if (model_plen == 16'd0)
                it.op = rvx_pkg::OP_J;
            else
            begin
                it.op = rvx_pkg::OP_LI; it.rd = rvx_pkg::REG_RA;
                it.imm = $urandom_range(0, model_plen - 1);
            end
        end
        return it;
    endfunction

    // hands one request to the block and records what it should produce
    task automatic send(input instr_t it, input bit typed, input rvx_pkg::rvx_result_t want);
        int                   gap;
        rvx_pkg::rvx_result_t r;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op <= it.op; dest_reg <= it.rd; src_a <= it.ra; src_b <= it.rb;
        immediate <= it.imm; target <= it.tgt;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        execute_instr(it, r);
        pending_results.insert(pending_results.size(), typed ? want : r);
    endtask

    task automatic write_plen(input logic [15:0] v);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= rvx_pkg::PADDR_PLEN; pwdata <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        model_plen = v;
        @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        rvx_pkg::rvx_result_t w;
        int                   n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                n = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge clk); while (!out_valid);
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: next_pc %0d", next_pc);
                fail_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (next_pc !== w.next_pc)
                begin
                    $error("next_pc exp %0d got %0d", w.next_pc, next_pc); fail_count++;
                end
                if (event_res !== w.event_res)
                begin
                    $error("event_res exp %0d got %0d", w.event_res, event_res); fail_count++;
                end
                if (value !== w.value)
                begin
                    $error("value exp %0h got %0h", w.value, value); fail_count++;
                end
                if (error_kind !== w.error_kind)
                begin
                    $error("error_kind exp %0d got %0d", w.error_kind, error_kind);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on handshakes
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** rv32im_subset_execute_unit: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rvx_pkg::rvx_result_t none;
        int                   k;
        logic [15:0]          plens [5];
        in_valid = 1'b0; op = '0; dest_reg = '0; src_a = '0; src_b = '0;
        immediate = '0; target = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        rst_n = 1'b0; fail_count = 0; idle_cycles = 0; hold_request = 1'b0;
        send_gap_max = 15; recv_stall_max = 15;
        foreach (gpr[i]) gpr[i] = 32'd0;
        gpr[rvx_pkg::REG_SP] = STACK;
        model_pc = '0; model_halted = 1'b0; model_plen = 16'hFFFF;
        none = '0;

        // directed list; only the first rows after reset carry typed results
        add_row('{mk(rvx_pkg::OP_LI, 5, 0, 0, 32'h8000_0000, 0), 1,
                  '{16'd1, rvx_pkg::EV_NONE, 0, rvx_pkg::ERR_NONE}});
        add_row('{mk(rvx_pkg::OP_LI, 6, 0, 0, 32'hFFFF_FFFF, 0), 1,
                  '{16'd2, rvx_pkg::EV_NONE, 0, rvx_pkg::ERR_NONE}});
        add_row('{mk(rvx_pkg::OP_DIV, 7, 5, 6, 0, 0), 0, none});  // most negative / -1
        add_row('{mk(rvx_pkg::OP_REM, 8, 5, 6, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_ADD, 0, 5, 6, 0, 0), 0, none});  // x0 stays zero
        add_row('{mk(rvx_pkg::OP_SLL, 9, 6, 5, 0, 0), 0, none});  // shift uses low five bits
        add_row('{mk(rvx_pkg::OP_SRLI, 9, 6, 0, 32'hFFFF_FFFF, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_SLLI, 9, 6, 0, 33, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_ADDI, 9, 0, 0, 32'h7FFF_FFFF, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_MUL, 9, 5, 6, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_SUB, 9, 0, 6, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_SW, 0, 0, 5, -STACK, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_SH, 0, 0, 6, -2, 0), 0, none});  // top of stack
        add_row('{mk(rvx_pkg::OP_SB, 0, 0, 9, 5 - STACK, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_LB, 12, 0, 0, 3 - STACK, 0), 0, none});  // sign extension
        add_row('{mk(rvx_pkg::OP_LH, 13, 0, 0, -2, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_LW, 14, 0, 0, -STACK, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_BEQ, 0, 5, 5, 0, 16'hFFFF), 0, none});
        add_row('{mk(rvx_pkg::OP_BNE, 0, 5, 5, 0, 0), 0, none});  // pc wraps to zero
        add_row('{mk(rvx_pkg::OP_BLT, 0, 5, 6, 0, 7), 0, none});
        add_row('{mk(rvx_pkg::OP_BGE, 0, 6, 5, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_BGT, 0, 6, 5, 0, 40), 0, none});
        add_row('{mk(rvx_pkg::OP_BLE, 0, 5, 0, 0, 50), 0, none});
        add_row('{mk(rvx_pkg::OP_LI, rvx_pkg::REG_A0, 0, 0, rvx_pkg::SVC_PINT, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_MV, rvx_pkg::REG_A1, 6, 0, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_ECALL, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_LI, rvx_pkg::REG_A0, 0, 0, rvx_pkg::SVC_PCHR, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_ECALL, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(rvx_pkg::OP_CALL, 0, 0, 0, 0, 1000), 0, none});
        add_row('{mk(rvx_pkg::OP_RET, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(6'd63, 31, 31, 31, 32'hFFFF_FFFF, 16'hFFFF), 0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) send(plan[i].ins, plan[i].typed, plan[i].want);

        // phases over program_length, extremes included
        plens = '{16'hFFFF, 16'd0, 16'($urandom), 16'd1, 16'hFFFF};
        for (int p = 0; p < 5; p++)
        begin
            write_plen(plens[p]);
            send_gap_max = (p == 3) ? 0 : 15;
            recv_stall_max = (p == 4) ? 0 : 15;
            if (p == 2) hold_request = 1'b1;  // lets the queue fill and stall requests
            for (int i = 0; i < PHASE_REQS; i++) send(next_instr(), 0, none);
        end

        // one terminating sequence: exit or one of the error kinds
        k = $urandom_range(0, 5);
        case (k)
            0:
            begin
                send(mk(rvx_pkg::OP_LI, rvx_pkg::REG_A0, 0, 0, rvx_pkg::SVC_EXIT, 0), 0, none);
                send(mk(rvx_pkg::OP_ECALL, 0, 0, 0, 0, 0), 0, none);
            end
            1: send(mk(rvx_pkg::OP_LW, $urandom_range(0, 1) ? 5'd0 : rvx_pkg::REG_SP,
                       0, 0, 0, 0), 0, none);
            2:
            begin
                send(mk(rvx_pkg::OP_LI, 6, 0, 0, 0, 0), 0, none);
                send(mk($urandom_range(0, 1) ? rvx_pkg::OP_DIV : rvx_pkg::OP_REM,
                        7, 8, 6, 0, 0), 0, none);
            end
            3:
            begin
                send(mk(rvx_pkg::OP_LI, rvx_pkg::REG_RA, 0, 0, 32'hFFFF_FFFF, 0), 0, none);
                send(mk(rvx_pkg::OP_RET, 0, 0, 0, 0, 0), 0, none);
            end
            4:
            begin
                send(mk(rvx_pkg::OP_LI, rvx_pkg::REG_A0, 0, 0, 32'd7, 0), 0, none);
                send(mk(rvx_pkg::OP_ECALL, 0, 0, 0, 0, 0), 0, none);
            end
            default: send(mk(rvx_pkg::OP_SW, 0, 0, 5, (STACK - 2) - gpr[rvx_pkg::REG_SP], 0),
                          0, none);
        endcase
        // the core is halted now and only echoes its pc
        for (int i = 0; i < 6; i++) send(next_instr(), 0, none);
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("** rv32im_subset_execute_unit: PASSED **");
        else
            $display("** rv32im_subset_execute_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rvx_pkg.sv
rtl/rvx_front.sv
rtl/rvx_div.sv
rtl/rvx_back.sv
rtl/rv32im_subset_execute_unit.sv
dv/rv32im_subset_execute_unit_test.sv
